// ===== design/dnd_pkg.sv =====
// Shared types and constants for the DNS name decompressor.
// Depends on nothing; dnd_parser and the top level use it by scoped names.
`default_nettype none

package dnd_pkg;

  localparam int MSG_BYTES  = 512;
  localparam int NAME_BYTES = 256;
  localparam int MAX_HOPS   = 16;

  localparam int MSG_AW  = $clog2(MSG_BYTES);
  localparam int NAME_AW = $clog2(NAME_BYTES);
  localparam int LEN_W   = $clog2(MSG_BYTES + 1);
  localparam int HOP_W   = $clog2(MAX_HOPS + 1);
  localparam int POS_W   = 14;
  localparam int CAP_W   = 9;
  localparam int EXT_W   = 15;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PARSE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_NO_SPACE  = 2'd3;

  localparam logic [7:0] LABEL_MAX = 8'd63;
  localparam logic [7:0] PTR_TAG   = 8'hC0;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]  command;
    logic [8:0]  position;
    logic [7:0]  byte_value;
    logic [13:0] start_offset;
    logic [9:0]  message_length;
  } in_t;

  typedef struct packed {
    logic [7:0] name_length;
    logic [1:0] status;
    logic [7:0] read_byte;
  } out_t;

  // Parser requests on the two store ports.
  typedef struct packed {
    logic [MSG_AW-1:0]  msg_addr;
    logic               name_we;
    logic [NAME_AW-1:0] name_addr;
    logic [7:0]         name_data;
  } parse_mem_t;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
    logic [7:0] name_length;
  } parse_res_t;

endpackage

`default_nettype wire

// ===== design/dnd_ram.sv =====
// Generic single-port synchronous RAM, registered read.
// Depends on nothing; used for the message store and the name store.
`default_nettype none

module dnd_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/dnd_parser.sv =====
// Label walker: reads the message store, follows pointers, copies labels
// into the name store. Depends on dnd_pkg.
`default_nettype none

module dnd_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [13:0]                start_offset,
  input  wire logic [9:0]                 message_length,
  input  wire logic [dnd_pkg::CAP_W-1:0]  cap,
  input  wire logic [7:0]                 msg_q,
  output dnd_pkg::parse_mem_t             mem_req,
  output dnd_pkg::parse_res_t             res
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_LEN   = 9'b000000100,
    S_PTR   = 9'b000001000,
    S_COPY  = 9'b000010000,
    S_DRAIN = 9'b000100000,
    S_DOT   = 9'b001000000,
    S_ZERO  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dnd_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [dnd_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [dnd_pkg::CAP_W-1:0]       cap_r, cap_nxt;
  logic [dnd_pkg::CAP_W-1:0]       wr_r, wr_nxt;
  logic [dnd_pkg::HOP_W-1:0]       hops_r, hops_nxt;
  logic [5:0]                      cnt_r, cnt_nxt;
  logic [5:0]                      hi6_r, hi6_nxt;
  logic [1:0]                      status_r, status_nxt;
  logic [dnd_pkg::CAP_W-1:0]       nlen_r, nlen_nxt;
  logic                            zseen_r, zseen_nxt;
  logic                            cp_valid_r, cp_valid_nxt;
  logic [dnd_pkg::NAME_AW-1:0]     cp_addr_r, cp_addr_nxt;
  logic [dnd_pkg::MSG_AW-1:0]      rd_addr;

  logic [dnd_pkg::EXT_W-1:0] pos_ext, len_ext, lab_end, ptr_pos;
  logic [dnd_pkg::CAP_W-1:0] room, need;

  assign pos_ext = dnd_pkg::EXT_W'(pos_r);
  assign len_ext = dnd_pkg::EXT_W'(len_r);
  assign lab_end = pos_ext + dnd_pkg::EXT_W'(1) + dnd_pkg::EXT_W'(msg_q);
  assign ptr_pos = dnd_pkg::EXT_W'({hi6_r, msg_q});
  assign room    = cap_r - wr_r;
  assign need    = dnd_pkg::CAP_W'(msg_q) + dnd_pkg::CAP_W'(2);

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    cap_nxt      = cap_r;
    wr_nxt       = wr_r;
    hops_nxt     = hops_r;
    cnt_nxt      = cnt_r;
    hi6_nxt      = hi6_r;
    status_nxt   = status_r;
    nlen_nxt     = nlen_r;
    zseen_nxt    = zseen_r;
    cp_valid_nxt = 1'b0;
    cp_addr_nxt  = cp_addr_r;
    rd_addr      = pos_r[dnd_pkg::MSG_AW-1:0];

    // Copied byte lands in the name store in the cycle after its read.
    if (cp_valid_r) begin
      if (msg_q == 8'd0) begin
        zseen_nxt = 1'b1;
      end else if (!zseen_r) begin
        nlen_nxt = nlen_r + dnd_pkg::CAP_W'(1);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          pos_nxt    = start_offset;
          len_nxt    = (dnd_pkg::EXT_W'(message_length) > dnd_pkg::EXT_W'(dnd_pkg::MSG_BYTES))
                       ? dnd_pkg::LEN_W'(dnd_pkg::MSG_BYTES)
                       : dnd_pkg::LEN_W'(message_length);
          cap_nxt    = cap;
          wr_nxt     = '0;
          hops_nxt   = '0;
          nlen_nxt   = '0;
          zseen_nxt  = 1'b0;
          status_nxt = (cap == '0) ? dnd_pkg::ST_NO_SPACE : dnd_pkg::ST_OK;
          state_nxt  = (cap == '0) ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (pos_ext < len_ext && wr_r < cap_r) begin
          state_nxt = S_LEN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LEN: begin
        if (msg_q <= dnd_pkg::LABEL_MAX) begin
          pos_nxt = pos_r + dnd_pkg::POS_W'(1);
          cnt_nxt = msg_q[5:0];
          if (msg_q == 8'd0) begin
            state_nxt = S_DONE;
          end else if (lab_end > len_ext) begin
            status_nxt = dnd_pkg::ST_MALFORMED;
            state_nxt  = S_DONE;
          end else if (need > room) begin
            status_nxt = dnd_pkg::ST_OVERFLOW;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_COPY;
          end
        end else if (msg_q >= dnd_pkg::PTR_TAG) begin
          if (pos_ext + dnd_pkg::EXT_W'(1) >= len_ext ||
              hops_r == dnd_pkg::HOP_W'(dnd_pkg::MAX_HOPS)) begin
            status_nxt = dnd_pkg::ST_MALFORMED;
            state_nxt  = S_DONE;
          end else begin
            hops_nxt  = hops_r + dnd_pkg::HOP_W'(1);
            hi6_nxt   = msg_q[5:0];
            rd_addr   = dnd_pkg::MSG_AW'(pos_r + dnd_pkg::POS_W'(1));
            state_nxt = S_PTR;
          end
        end else begin
          status_nxt = dnd_pkg::ST_MALFORMED;
          state_nxt  = S_DONE;
        end
      end
      S_PTR: begin
        if (ptr_pos >= len_ext) begin
          status_nxt = dnd_pkg::ST_MALFORMED;
          state_nxt  = S_DONE;
        end else begin
          pos_nxt   = dnd_pkg::POS_W'(ptr_pos);
          rd_addr   = dnd_pkg::MSG_AW'(ptr_pos);
          state_nxt = S_LEN;
        end
      end
      S_COPY: begin
        cp_valid_nxt = 1'b1;
        cp_addr_nxt  = wr_r[dnd_pkg::NAME_AW-1:0];
        pos_nxt      = pos_r + dnd_pkg::POS_W'(1);
        wr_nxt       = wr_r + dnd_pkg::CAP_W'(1);
        cnt_nxt      = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DOT;
      end
      S_DOT: begin
        wr_nxt = wr_r + dnd_pkg::CAP_W'(1);
        if (!zseen_r) begin
          nlen_nxt = nlen_r + dnd_pkg::CAP_W'(1);
        end
        state_nxt = S_ZERO;
      end
      S_ZERO: begin
        state_nxt = S_CHECK;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_req.msg_addr  = rd_addr;
    mem_req.name_we   = 1'b0;
    mem_req.name_addr = wr_r[dnd_pkg::NAME_AW-1:0];
    mem_req.name_data = 8'd0;
    priority if (cp_valid_r) begin
      mem_req.name_we   = 1'b1;
      mem_req.name_addr = cp_addr_r;
      mem_req.name_data = msg_q;
    end else if (state_r == S_DOT) begin
      mem_req.name_we   = 1'b1;
      mem_req.name_data = dnd_pkg::DOT_CHAR;
    end else if (state_r == S_ZERO) begin
      mem_req.name_we = 1'b1;
    end else if (state_r == S_IDLE && go && cap != '0) begin
      mem_req.name_we   = 1'b1;
      mem_req.name_addr = '0;
    end else begin
      mem_req.name_we = 1'b0;
    end
  end

  assign res.done        = (state_r == S_DONE);
  assign res.status      = status_r;
  assign res.name_length = nlen_r[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cp_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cp_valid_r <= cp_valid_nxt;
    end
    pos_r     <= pos_nxt;
    len_r     <= len_nxt;
    cap_r     <= cap_nxt;
    wr_r      <= wr_nxt;
    hops_r    <= hops_nxt;
    cnt_r     <= cnt_nxt;
    hi6_r     <= hi6_nxt;
    status_r  <= status_nxt;
    nlen_r    <= nlen_nxt;
    zseen_r   <= zseen_nxt;
    cp_addr_r <= cp_addr_nxt;
  end

endmodule

`default_nettype wire

// ===== design/dns_name_decompressor.sv =====
// DNS name decompressor: loads run one per cycle, reads one per cycle, while
// no parse holds busy, each with its result registered in st1 and then in the
// output register. A parse holds busy from its start until its result, for a
// time that grows with each label, label byte and pointer hop; the single-port
// message store bounds the walk. Results cannot be held off by the receiver.
// Synchronous active-low reset clears control state and sets capacity to 256.
// Depends on dnd_pkg, dnd_ram and dnd_parser.
`default_nettype none

module dns_name_decompressor (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire dnd_pkg::in_t              in_item,
  output logic                           out_valid,
  output dnd_pkg::out_t                  out_result,
  input  wire logic                      cfg_we,
  input  wire logic [dnd_pkg::CAP_W-1:0] cfg_wdata
);

  logic                           busy_r, busy_nxt;
  logic [dnd_pkg::CAP_W-1:0]      cap_cfg_r;
  logic [dnd_pkg::CAP_W-1:0]      cap_eff;
  logic                           accept;
  logic                           go;
  logic                           load_we;

  // One-stage pipe for load and read transfers: the name store answers here.
  logic                           st1_valid_r;
  logic                           st1_rd_r;

  logic                           out_valid_r, out_valid_nxt;
  dnd_pkg::out_t                  out_r, out_nxt;

  dnd_pkg::parse_mem_t            mem_req;
  dnd_pkg::parse_res_t            res;

  logic [dnd_pkg::MSG_AW-1:0]     msg_addr;
  logic [7:0]                     msg_q;
  logic                           name_we;
  logic [dnd_pkg::NAME_AW-1:0]    name_addr;
  logic [7:0]                     name_wdata;
  logic [7:0]                     name_q;

  assign accept = start && !busy_r;
  assign go     = accept && (in_item.command == dnd_pkg::CMD_PARSE);

  // Drop loads beyond the store.
  assign load_we = accept && (in_item.command == dnd_pkg::CMD_LOAD) &&
                   (dnd_pkg::EXT_W'(in_item.position) < dnd_pkg::EXT_W'(dnd_pkg::MSG_BYTES));

  // Clamp the configured capacity to the name store size.
  assign cap_eff = (dnd_pkg::EXT_W'(cap_cfg_r) > dnd_pkg::EXT_W'(dnd_pkg::NAME_BYTES))
                   ? dnd_pkg::CAP_W'(dnd_pkg::NAME_BYTES) : cap_cfg_r;

  // The parser owns both store ports while busy; loads and reads only run when idle.
  assign msg_addr   = busy_r ? mem_req.msg_addr : dnd_pkg::MSG_AW'(in_item.position);
  assign name_we    = mem_req.name_we;
  assign name_addr  = (busy_r || go) ? mem_req.name_addr
                                     : dnd_pkg::NAME_AW'(in_item.position);
  assign name_wdata = mem_req.name_data;

  dnd_ram #(
    .DEPTH (dnd_pkg::MSG_BYTES),
    .WIDTH (8)
  ) u_msg_ram (
    .clk   (clk),
    .we    (load_we),
    .addr  (msg_addr),
    .wdata (in_item.byte_value),
    .rdata (msg_q)
  );

  dnd_ram #(
    .DEPTH (dnd_pkg::NAME_BYTES),
    .WIDTH (8)
  ) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .addr  (name_addr),
    .wdata (name_wdata),
    .rdata (name_q)
  );

  dnd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (go),
    .start_offset   (in_item.start_offset),
    .message_length (in_item.message_length),
    .cap            (cap_eff),
    .msg_q          (msg_q),
    .mem_req        (mem_req),
    .res            (res)
  );

  // Hold busy from a parse transfer until its result leaves.
  always_comb begin
    busy_nxt = busy_r;
    if (go) begin
      busy_nxt = 1'b1;
    end else if (res.done) begin
      busy_nxt = 1'b0;
    end
  end

  // Select the result: a finishing parse, or a load/read held in st1.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    priority if (res.done) begin
      out_valid_nxt       = 1'b1;
      out_nxt.name_length = res.name_length;
      out_nxt.status      = res.status;
    end else if (st1_valid_r) begin
      out_valid_nxt     = 1'b1;
      out_nxt.read_byte = st1_rd_r ? name_q : 8'd0;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cap_cfg_r   <= dnd_pkg::CAP_RESET;
      st1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      if (cfg_we) begin
        cap_cfg_r <= cfg_wdata;
      end
      st1_valid_r <= accept && !go;
      out_valid_r <= out_valid_nxt;
    end
    st1_rd_r <= (in_item.command == dnd_pkg::CMD_READ) &&
                (dnd_pkg::EXT_W'(in_item.position) < dnd_pkg::EXT_W'(dnd_pkg::NAME_BYTES));
    out_r    <= out_nxt;
  end

  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dns_name_decompressor: load, parse and read commands
// are checked in order against a local model of the message and name stores.
// Depends on dnd_pkg and the design sources; reads no files.

module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRINT_LIMIT    = 200;
  localparam int PHASE_ITEMS    = 50;
  localparam int OFFSET_MAX     = 16383;
  localparam int LENGTH_MAX     = 1023;
  localparam int POSITION_MAX   = 511;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [7:0] PTR_LOW_MASK = 8'h3F;

  // Directed message, byte 0 first:
  //   0: "x" then root      3: reserved high    4: pointer to 0
  //   6: pointer to itself   8: pointer past end 10: reserved low
  //  11: label holding a zero byte, then root
  localparam int WALK_LEN = 15;
  localparam logic [WALK_LEN*8-1:0] WALK_MSG = {
    8'h01, 8'h78, 8'h00, 8'hBF, 8'hC0, 8'h00, 8'hC0, 8'h06,
    8'hFF, 8'hFF, 8'h40, 8'h02, 8'h00, 8'h7A, 8'h00
  };

  typedef struct {
    dnd_pkg::in_t  item;
    dnd_pkg::out_t result;
  } owed_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  dnd_pkg::in_t              in_item;
  logic                      out_valid;
  dnd_pkg::out_t             out_result;
  logic                      cfg_we;
  logic [dnd_pkg::CAP_W-1:0] cfg_wdata;

  dns_name_decompressor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Local copy of the block state.
  logic [7:0]  msg_mem  [dnd_pkg::MSG_BYTES];
  logic [7:0]  name_mem [dnd_pkg::NAME_BYTES];
  int unsigned capacity;
  int unsigned name_fill;  // name entries written so far, always from index 0
  int unsigned msg_fill;   // message bytes written contiguously from offset 0

  int unsigned name_starts[$];
  logic [7:0]  seg_bytes[$];
  owed_t       owed_results[$];
  owed_t       got_item;
  int          idle_pct;
  int          errors;
  int          quiet_cycles;
  int          transfers;
  int          n_load, n_parse, n_read, n_unused, n_cap_writes;
  int          status_seen[4];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Walk the labels from first, copy them into the name store, return status.
  function automatic logic [1:0] walk_name(int unsigned first, int unsigned msg_len,
                                           output int unsigned name_len);
    int unsigned cap, lim, pos, wr, hops, lab, b, k;
    logic [1:0]  st;
    bit          found, bad;
    name_len = 0;
    cap = (capacity > dnd_pkg::NAME_BYTES) ? dnd_pkg::NAME_BYTES : capacity;
    lim = (msg_len > dnd_pkg::MSG_BYTES) ? dnd_pkg::MSG_BYTES : msg_len;
    if (cap == 0) return dnd_pkg::ST_NO_SPACE;
    pos  = first;
    wr   = 0;
    hops = 0;
    st   = dnd_pkg::ST_OK;
    name_mem[0] = 8'h00;
    while (pos < lim && wr < cap) begin
      lab   = 0;
      found = 0;
      bad   = 0;
      while (!found && !bad) begin
        b = 32'(msg_mem[pos]);
        if (b <= dnd_pkg::LABEL_MAX) begin
          lab   = b;
          pos++;
          found = 1;
        end else if (b >= dnd_pkg::PTR_TAG) begin
          hops++;
          if (pos + 1 >= lim || hops > dnd_pkg::MAX_HOPS) begin
            bad = 1;
          end else begin
            pos = ((b & 32'(PTR_LOW_MASK)) << 8) | 32'(msg_mem[pos + 1]);
            if (pos >= lim) bad = 1;
          end
        end else begin
          bad = 1;
        end
      end
      if (bad) begin
        st = dnd_pkg::ST_MALFORMED;
        break;
      end
      if (lab == 0) break;
      if (pos + lab > lim) begin
        st = dnd_pkg::ST_MALFORMED;
        break;
      end
      if (lab + 2 > cap - wr) begin
        st = dnd_pkg::ST_OVERFLOW;
        break;
      end
      for (k = 0; k < lab; k++) name_mem[wr + k] = msg_mem[pos + k];
      pos += lab;
      wr  += lab;
      name_mem[wr]     = dnd_pkg::DOT_CHAR;
      name_mem[wr + 1] = 8'h00;
      wr++;
    end
    if (wr + 1 > name_fill) name_fill = wr + 1;
    k = 0;
    while (k < wr && name_mem[k] != 8'h00) k++;
    name_len = k % 256;
    return st;
  endfunction

  function automatic dnd_pkg::out_t answer_for(dnd_pkg::in_t it);
    dnd_pkg::out_t r;
    int unsigned   nlen;
    r = '0;
    case (it.command)
      dnd_pkg::CMD_LOAD: begin
        msg_mem[it.position] = it.byte_value;
        n_load++;
      end
      dnd_pkg::CMD_PARSE: begin
        r.status      = walk_name(32'(it.start_offset), 32'(it.message_length), nlen);
        r.name_length = nlen[7:0];
        status_seen[r.status]++;
        n_parse++;
      end
      dnd_pkg::CMD_READ: begin
        if (it.position < dnd_pkg::NAME_BYTES) r.read_byte = name_mem[it.position];
        n_read++;
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  // Hold start until the block takes the transfer, then record what it owes.
  task automatic send_item(dnd_pkg::in_t it);
    owed_t o;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    o.item   = it;
    o.result = answer_for(it);
    owed_results.push_back(o);
    transfers++;
  endtask

  task automatic hold_off();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Fields that the command ignores get random values.
  task automatic issue(logic [1:0] cmd, int unsigned pos, int unsigned val,
                       int unsigned first, int unsigned len);
    dnd_pkg::in_t it;
    logic [63:0]  noise;
    noise = {$urandom, $urandom};
    it = noise[$bits(dnd_pkg::in_t)-1:0];
    it.command = cmd;
    if (cmd == dnd_pkg::CMD_LOAD || cmd == dnd_pkg::CMD_READ) it.position = pos[8:0];
    if (cmd == dnd_pkg::CMD_LOAD) it.byte_value = val[7:0];
    if (cmd == dnd_pkg::CMD_PARSE) begin
      it.start_offset   = first[13:0];
      it.message_length = len[9:0];
    end
    hold_off();
    send_item(it);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[dnd_pkg::CAP_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    capacity = v;
    n_cap_writes++;
  endtask

  // Build a run of names at base: labels, then a root, a pointer, junk or nothing.
  task automatic build_segment(int unsigned base, int unsigned want);
    int unsigned at, llen, r, tgt;
    seg_bytes.delete();
    while (seg_bytes.size() < want && base + seg_bytes.size() < dnd_pkg::MSG_BYTES) begin
      at = base + seg_bytes.size();
      name_starts.push_back(at);
      repeat ($urandom_range(4)) begin
        r = $urandom_range(99);
        llen = (r < 80) ? $urandom_range(1, 12) :
               (r < 95) ? $urandom_range(13, 62) : 32'(dnd_pkg::LABEL_MAX);
        seg_bytes.push_back(8'(llen));
        repeat (llen) begin
          if ($urandom_range(99) < 85) seg_bytes.push_back(8'(32'h61 + $urandom_range(25)));
          else seg_bytes.push_back(8'($urandom_range(255)));
        end
      end
      r = $urandom_range(99);
      if (r < 45) begin
        seg_bytes.push_back(8'h00);
      end else if (r < 88) begin
        if (r < 75) tgt = name_starts[$urandom_range(name_starts.size() - 1)];
        else if (r < 82) tgt = base + seg_bytes.size();
        else tgt = $urandom_range(OFFSET_MAX);
        seg_bytes.push_back(dnd_pkg::PTR_TAG | {2'b00, tgt[13:8]});
        seg_bytes.push_back(tgt[7:0]);
      end else if (r < 94) begin
        seg_bytes.push_back(8'($urandom_range(32'(dnd_pkg::LABEL_MAX) + 1,
                                              32'(dnd_pkg::PTR_TAG) - 1)));
      end
    end
    while (base + seg_bytes.size() > dnd_pkg::MSG_BYTES) void'(seg_bytes.pop_back());
  endtask

  task automatic load_segment(int unsigned base);
    foreach (seg_bytes[k]) issue(dnd_pkg::CMD_LOAD, base + k, 32'(seg_bytes[k]), 0, 0);
    if (base + seg_bytes.size() > msg_fill) msg_fill = base + seg_bytes.size();
  endtask

  // Any parse whose walk could touch message bytes stays inside the loaded prefix.
  task automatic parse_random();
    int unsigned first, len, eff, r;
    r = $urandom_range(99);
    if (msg_fill > 0 && r < 75) begin
      first = name_starts[$urandom_range(name_starts.size() - 1)];
      len   = msg_fill;
      if (msg_fill == dnd_pkg::MSG_BYTES && $urandom_range(1))
        len = dnd_pkg::MSG_BYTES + $urandom_range(LENGTH_MAX - dnd_pkg::MSG_BYTES);
    end else if (msg_fill > 0 && r < 90) begin
      len   = $urandom_range(msg_fill);
      first = $urandom_range(msg_fill);
    end else begin
      first = $urandom_range(OFFSET_MAX);
      len   = $urandom_range(LENGTH_MAX);
      eff   = (len > dnd_pkg::MSG_BYTES) ? dnd_pkg::MSG_BYTES : len;
      if (first < eff && eff > msg_fill) len = msg_fill;
    end
    issue(dnd_pkg::CMD_PARSE, 0, 0, first, len);
  endtask

  // Read only name entries that some parse has written, or out of range.
  task automatic read_random();
    if (name_fill > 0 && $urandom_range(99) < 80)
      issue(dnd_pkg::CMD_READ, $urandom_range(name_fill - 1), 0, 0, 0);
    else
      issue(dnd_pkg::CMD_READ, $urandom_range(dnd_pkg::NAME_BYTES, POSITION_MAX), 0, 0, 0);
  endtask

  task automatic run_round();
    int unsigned base, r;
    if (msg_fill == 0 || (msg_fill < dnd_pkg::MSG_BYTES && $urandom_range(99) < 60))
      base = msg_fill;
    else base = $urandom_range(msg_fill - 1);
    build_segment(base, $urandom_range(8, 40));
    load_segment(base);
    repeat ($urandom_range(6, 12)) begin
      parse_random();
      repeat ($urandom_range(3)) read_random();
      r = $urandom_range(99);
      if (r < 5) issue(CMD_UNUSED, 0, 0, 0, 0);
      else if (r < 10 && msg_fill > 0)
        issue(dnd_pkg::CMD_LOAD, $urandom_range(msg_fill - 1), $urandom_range(255), 0, 0);
    end
  endtask

  task automatic run_phase(int pct, int unsigned cap);
    int target;
    set_capacity(cap);
    idle_pct = pct;
    target = transfers + PHASE_ITEMS;
    while (transfers < target) run_round();
  endtask

  task automatic test_range_and_unused();
    idle_pct = 0;
    issue(dnd_pkg::CMD_READ, POSITION_MAX, 0, 0, 0);
    hold_off();
    send_item('1);
  endtask

  task automatic test_label_walk();
    for (int k = 0; k < WALK_LEN; k++)
      issue(dnd_pkg::CMD_LOAD, k, 32'(WALK_MSG[(WALK_LEN - 1 - k)*8 +: 8]), 0, 0);
    msg_fill = WALK_LEN;
    name_starts.push_back(0);
    name_starts.push_back(4);
    name_starts.push_back(11);
    issue(dnd_pkg::CMD_PARSE, 0, 0, 0, WALK_LEN);           // plain label
    issue(dnd_pkg::CMD_PARSE, 0, 0, 3, WALK_LEN);           // reserved length, high edge
    issue(dnd_pkg::CMD_PARSE, 0, 0, 10, WALK_LEN);          // reserved length, low edge
    issue(dnd_pkg::CMD_PARSE, 0, 0, 4, WALK_LEN);           // pointer hop
    issue(dnd_pkg::CMD_PARSE, 0, 0, 6, WALK_LEN);           // pointer loop
    issue(dnd_pkg::CMD_PARSE, 0, 0, 8, WALK_LEN);           // pointer target past end
    issue(dnd_pkg::CMD_PARSE, 0, 0, 8, 9);                  // pointer second byte past end
    issue(dnd_pkg::CMD_PARSE, 0, 0, 11, WALK_LEN);          // zero byte inside a label
    issue(dnd_pkg::CMD_READ, 1, 0, 0, 0);
    issue(dnd_pkg::CMD_PARSE, 0, 0, 11, 13);                // label runs past end
    issue(dnd_pkg::CMD_PARSE, 0, 0, OFFSET_MAX, LENGTH_MAX); // start past end
  endtask

  task automatic test_capacity_limits();
    set_capacity(0);
    issue(dnd_pkg::CMD_PARSE, 0, 0, 0, WALK_LEN);
    set_capacity(1);
    issue(dnd_pkg::CMD_PARSE, 0, 0, 0, WALK_LEN);
    set_capacity(3);
    issue(dnd_pkg::CMD_PARSE, 0, 0, 4, WALK_LEN);
    issue(dnd_pkg::CMD_READ, 0, 0, 0, 0);
  endtask

  // Fill the message to its last byte so pointers and lengths reach the top.
  task automatic test_full_message();
    int unsigned base;
    idle_pct = 22;
    base = msg_fill;
    build_segment(base, dnd_pkg::MSG_BYTES - base);
    load_segment(base);
    msg_fill = dnd_pkg::MSG_BYTES;
    repeat (12) begin
      parse_random();
      read_random();
    end
  endtask

  // Check every strobed result against the oldest owed one; watch for a hang.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed",
                 quiet_cycles, owed_results.size());
        $display("dns_name_decompressor regression: fail");
        $finish;
      end else if (out_valid === 1'b1) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("result strobed with nothing owed");
        end else begin
          got_item = owed_results.pop_front();
          if (out_result.name_length !== got_item.result.name_length)
            flag_mismatch($sformatf("cmd %0d name_length got %0d want %0d",
                          got_item.item.command, out_result.name_length,
                          got_item.result.name_length));
          if (out_result.status !== got_item.result.status)
            flag_mismatch($sformatf("cmd %0d status got %0d want %0d",
                          got_item.item.command, out_result.status,
                          got_item.result.status));
          if (out_result.read_byte !== got_item.result.read_byte)
            flag_mismatch($sformatf("cmd %0d pos %0d read_byte got %0h want %0h",
                          got_item.item.command, got_item.item.position,
                          out_result.read_byte, got_item.result.read_byte));
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    capacity  = 32'(dnd_pkg::CAP_RESET);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_range_and_unused();
    test_label_walk();
    test_capacity_limits();
    run_phase(0, 32'(dnd_pkg::CAP_RESET));
    run_phase(80, $urandom_range(1, 40));
    test_full_message();
    run_phase(0, dnd_pkg::NAME_BYTES - 1);
    run_phase(22, $urandom_range(41, 200));
    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d transfers: %0d loads, %0d parses, %0d reads, %0d unused, %0d cap writes",
             transfers, n_load, n_parse, n_read, n_unused, n_cap_writes);
    $display("parse outcomes: %0d ok, %0d malformed, %0d overflow, %0d no space; %0d mismatches",
             status_seen[dnd_pkg::ST_OK], status_seen[dnd_pkg::ST_MALFORMED],
             status_seen[dnd_pkg::ST_OVERFLOW], status_seen[dnd_pkg::ST_NO_SPACE], errors);
    if (errors == 0) begin
      $display("dns_name_decompressor regression: pass");
    end else begin
      $display("dns_name_decompressor regression: fail");
    end
    $finish;
  end

endmodule
